// ----- rtl/rtc_bcd_datetime_validator_macros.svh -----
// Assertion macros shared by the RTC snapshot validator RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef RTC_BCD_DATETIME_VALIDATOR_MACROS_SVH
`define RTC_BCD_DATETIME_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside of reset
`define RBDV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Check a property at every clock edge, reset included
`define RBDV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define RBDV_ASSERT(lbl, prop, msg)
`define RBDV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/rbdv_pkg.sv -----
// Shared constants, flag bit positions and calendar tables for the RTC validator.
// No dependencies.
package rbdv_pkg;

    localparam int unsigned BCD_W   = 8;
    localparam int unsigned VAL_W   = 7;
    localparam int unsigned FLAGS_W = 12;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned S_TDATA_W = 7 * BCD_W;
    localparam int unsigned M_TDATA_W = 32;

    // Flag word bit positions
    localparam int unsigned FLAG_NOT24H  = 4;
    localparam int unsigned FLAG_PWRFAIL = 5;
    localparam int unsigned FLAG_YEAR    = 6;
    localparam int unsigned FLAG_MONTH   = 7;
    localparam int unsigned FLAG_DAY     = 8;
    localparam int unsigned FLAG_HOUR    = 9;
    localparam int unsigned FLAG_MINUTE  = 10;
    localparam int unsigned FLAG_SECOND  = 11;

    // Status byte bits
    localparam int unsigned STAT_PWRFAIL = 7;
    localparam int unsigned STAT_24H     = 6;

    // Range limits
    localparam logic [VAL_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [VAL_W-1:0] HOUR_MAX   = 7'd24;
    localparam logic [VAL_W-1:0] MINUTE_MAX = 7'd60;
    localparam logic [VAL_W-1:0] SECOND_MAX = 7'd60;
    localparam logic [8:0]       DAYS_PER_YEAR = 9'd365;

    // Days in a month, February as non-leap
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:                         len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
            default:                      len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the whole months before this one, non-leap year
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Flags and day count from one snapshot, passed between the check and the top level
    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [COUNT_W-1:0] count;
    } rbdv_result_t;

endpackage

// ----- rtl/rbdv_bcd_decode.sv -----
// Decodes one BCD byte into its binary value and a bad-digit flag.
// Depends on rbdv_pkg.
module rbdv_bcd_decode
    import rbdv_pkg::*;
(
    input  logic [BCD_W-1:0] raw,
    output logic [VAL_W-1:0] val,
    output logic             bad
);

    logic [3:0] hi;
    logic [3:0] lo;
    logic [7:0] sum;

    assign hi = raw[7:4];
    assign lo = raw[3:0];

    // Flag either digit at ten or above
    assign bad = (hi > 4'd9) || (lo > 4'd9);

    // hi*10 + lo as shifts and adds
    assign sum = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
    assign val = sum[VAL_W-1:0];

endmodule

// ----- rtl/rbdv_check.sv -----
// Range checks and day count for one registered RTC snapshot.
// Depends on rbdv_pkg and rbdv_bcd_decode.
module rbdv_check
    import rbdv_pkg::*;
(
    input  logic [BCD_W-1:0] status_byte,
    input  logic [BCD_W-1:0] year_bcd,
    input  logic [BCD_W-1:0] month_bcd,
    input  logic [BCD_W-1:0] day_bcd,
    input  logic [BCD_W-1:0] hour_bcd,
    input  logic [BCD_W-1:0] minute_bcd,
    input  logic [BCD_W-1:0] second_bcd,
    output rbdv_result_t     result
);

    logic [VAL_W-1:0] year_val, month_val, day_val, hour_val, minute_val, second_val;
    logic             year_bad, month_bad, day_bad, hour_bad, minute_bad, second_bad;
    logic             month_ok;
    logic             leap;
    logic [3:0]       month_idx;
    logic [5:0]       day_lim;
    logic             day_over;
    logic             date_bad;
    logic [6:0]       year_m1;
    logic [15:0]      year_days;
    logic [15:0]      count;
    logic [FLAGS_W-1:0] flags;

    rbdv_bcd_decode u_dec_year   (.raw(year_bcd),   .val(year_val),   .bad(year_bad));
    rbdv_bcd_decode u_dec_month  (.raw(month_bcd),  .val(month_val),  .bad(month_bad));
    rbdv_bcd_decode u_dec_day    (.raw(day_bcd),    .val(day_val),    .bad(day_bad));
    rbdv_bcd_decode u_dec_hour   (.raw(hour_bcd),   .val(hour_val),   .bad(hour_bad));
    rbdv_bcd_decode u_dec_minute (.raw(minute_bcd), .val(minute_val), .bad(minute_bad));
    rbdv_bcd_decode u_dec_second (.raw(second_bcd), .val(second_val), .bad(second_bad));

    // Within one century every fourth year is leap, year 00 included
    assign leap = !year_bad && (year_val[1:0] == 2'b00);

    assign month_ok  = !month_bad && (month_val != '0) && (month_val <= MONTH_MAX);
    assign month_idx = month_val[3:0];

    // Month end, with February stretched in a leap year
    assign day_lim  = {1'b0, month_len(month_idx)}
                    + {5'd0, (month_idx == 4'd2) && leap};
    assign day_over = month_ok && ({1'b0, day_val} > {1'b0, day_lim});

    // Build the flag word
    always_comb begin
        flags = '0;
        flags[FLAG_PWRFAIL] = status_byte[STAT_PWRFAIL];
        flags[FLAG_NOT24H]  = !status_byte[STAT_24H];
        flags[FLAG_YEAR]    = year_bad;
        flags[FLAG_MONTH]   = !month_ok;
        flags[FLAG_DAY]     = day_bad || day_over;
        flags[FLAG_HOUR]    = hour_bad || (hour_val > HOUR_MAX);
        flags[FLAG_MINUTE]  = minute_bad || (minute_val > MINUTE_MAX);
        flags[FLAG_SECOND]  = second_bad || (second_val > SECOND_MAX);
    end

    assign date_bad = flags[FLAG_YEAR] || flags[FLAG_MONTH] || flags[FLAG_DAY];

    // Whole earlier years: (y-1)*365 + (y-1)/4, nothing for year 00
    assign year_m1   = (year_val == '0) ? 7'd0 : (year_val - 7'd1);
    assign year_days = ({9'd0, year_m1} * {7'd0, DAYS_PER_YEAR}) + {11'd0, year_m1[6:2]};

    // Add months, leap day and day of month
    assign count = year_days
                 + {7'd0, days_before(month_idx)}
                 + {15'd0, (month_val > 7'd2) && leap}
                 + {9'd0, day_val};

    assign result.flags = flags;
    assign result.count = date_bad ? '0 : count;

endmodule

// ----- rtl/rtc_bcd_datetime_validator.sv -----
// Top level of the RTC snapshot validator: input register, check logic, result register.
// Depends on rbdv_pkg, rbdv_check and the assertion macro header.
//
//   channel  dir  tdata fields (low bit up)                                      width
//   s_       in   status_byte, year_bcd, month_bcd, day_bcd, hour_bcd,              56
//                 minute_bcd, second_bcd
//   m_       out  error_flags, day_count, 4 zero bits                             32
//
// One beat in and one beat out per cycle sustained while m_tready is high. A taken beat
// is held in the input register, and m_tvalid rises when its result is loaded into the
// result register; between the two lies the single pass of decode, range checks and
// the 7x9 bit constant multiply.
// aresetn is synchronous and clears both valid bits; payload registers are not reset.
// While m_tready is low the result holds, the input stage keeps taking a beat until
// it is full, and then s_tready drops.
`include "rtc_bcd_datetime_validator_macros.svh"

module rtc_bcd_datetime_validator
    import rbdv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // status_byte[7:0], year_bcd[15:8], month_bcd[23:16], day_bcd[31:24],
    // hour_bcd[39:32], minute_bcd[47:40], second_bcd[55:48]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // error_flags[11:0], day_count[27:12], zero[31:28]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    rbdv_result_t         res_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rbdv_result_t         res_comb;
    logic                 out_en;

    // Result stage may load when it is empty or being drained
    assign out_en   = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_en;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_en ? in_valid_reg : out_valid_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture an input beat
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    rbdv_check u_check (
        .status_byte (in_data_reg[7:0]),
        .year_bcd    (in_data_reg[15:8]),
        .month_bcd   (in_data_reg[23:16]),
        .day_bcd     (in_data_reg[31:24]),
        .hour_bcd    (in_data_reg[39:32]),
        .minute_bcd  (in_data_reg[47:40]),
        .second_bcd  (in_data_reg[55:48]),
        .result      (res_comb)
    );

    // Advance the checked beat into the result register
    always_ff @(posedge aclk) begin
        if (out_en && in_valid_reg) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.count, res_reg.flags};

    `RBDV_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !in_valid_reg && !out_valid_reg, "valid bits not cleared by reset")
    `RBDV_ASSERT(a_stage_moves, in_valid_reg && out_en |=> out_valid_reg, "checked beat did not reach the result register")
    `RBDV_ASSERT(a_stage_holds, in_valid_reg && !out_en |=> in_valid_reg && $stable(in_data_reg), "input stage lost a beat while stalled")
    `RBDV_ASSERT(a_count_zero, out_valid_reg && (res_reg.flags[FLAG_YEAR] || res_reg.flags[FLAG_MONTH] || res_reg.flags[FLAG_DAY]) |-> res_reg.count == '0, "day count not zero with a date flag set")
    `RBDV_ASSERT(a_low_flags_zero, out_valid_reg |-> res_reg.flags[3:0] == 4'b0000, "reserved flag bits set")

endmodule
